// ----- rtl/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and codes for the command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 8;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_MODE       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HANDLER_ENABLED = 8'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED = 3'd0,
      ST_HEADER  = 3'd1,
      ST_DATA    = 3'd2,
      ST_GOOD    = 3'd3,
      ST_BAD     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_LEN   = 5'b00010,
      PH_CMD   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic              sync_mode;
      logic              handler_enabled;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } beat_type;

endpackage

`default_nettype wire

// ----- rtl/cfp_if.sv -----
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channel interfaces for the command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_req_if import cfp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_rsp_if import cfp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   data_byte;
   logic [BYTE_W-1:0]   data_index;
   logic [BYTE_W-1:0]   command_code;
   logic [BYTE_W-1:0]   frame_length;
   logic                deliver;

   modport source (output valid, output status, output data_byte, output data_index,
                   output command_code, output frame_length, output deliver,
                   input ready);
   modport sink   (input valid, input status, input data_byte, input data_index,
                   input command_code, input frame_length, input deliver,
                   output ready);
endinterface

interface cfp_csr_if import cfp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/cfp_csr.sv -----
// ----------------------------------------------------------------------------
// cfp_csr
// Configuration registers: start byte, sync mode, handler enable.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_csr import cfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   cfp_csr_if.sink      csr_bus,
   output cfg_type      cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_START_BYTE:      cfg_in.start_byte      = csr_bus.wdata;
            CSR_SYNC_MODE:       cfg_in.sync_mode       = csr_bus.wdata[0];
            CSR_HANDLER_ENABLED: cfg_in.handler_enabled = csr_bus.wdata[0];
            default: ;   // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/cfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// cfp_in_stage
// Input register: captures one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_in_stage import cfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   cfp_req_if.sink      req_bus,
   input  wire logic    take,
   output beat_type     beat
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_bus.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

`default_nettype wire

// ----- rtl/cfp_parser.sv -----
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state, per-byte decode and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_parser import cfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire beat_type beat,
   input  wire cfg_type cfg,
   output logic         take,
   cfp_rsp_if.source    rsp_bus
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] check_ff, check_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [BYTE_W-1:0] dbyte_ff, dbyte_in;
   logic [BYTE_W-1:0] dindex_ff, dindex_in;
   logic [BYTE_W-1:0] cmd_out_ff, len_out_ff;
   logic              deliver_ff, deliver_in;

   logic [BYTE_W-1:0] b;
   logic [BYTE_W:0]   count_plus;

   assign take       = beat.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign b          = beat.rx_byte;
   assign count_plus = {1'b0, count_ff} + {{BYTE_W{1'b0}}, 1'b1};

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      check_in   = check_ff;
      status_in  = ST_IGNORED;
      dbyte_in   = '0;
      dindex_in  = '0;
      deliver_in = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            len_in    = b;
            check_in  = b;
            phase_in  = PH_CMD;
            status_in = ST_HEADER;
         end
         PH_CMD: begin
            cmd_in    = b;
            check_in  = check_ff ^ b;
            count_in  = '0;
            // length zero behaves as length one
            phase_in  = (len_ff <= 8'd1) ? PH_CHECK : PH_DATA;
            status_in = ST_HEADER;
         end
         PH_DATA: begin
            dbyte_in  = b;
            dindex_in = count_ff;
            check_in  = check_ff ^ b;
            count_in  = count_plus[BYTE_W-1:0];
            // last data byte once count+2 reaches the length
            if ((count_plus + 9'd1) >= {1'b0, len_ff}) begin
               phase_in = PH_CHECK;
            end
            status_in = ST_DATA;
         end
         PH_CHECK: begin
            phase_in = PH_IDLE;
            if (check_ff == b) begin
               status_in  = ST_GOOD;
               deliver_in = !cfg.sync_mode && cfg.handler_enabled;
            end else begin
               status_in = ST_BAD;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (b == cfg.start_byte) begin
               len_in    = '0;
               cmd_in    = '0;
               count_in  = '0;
               check_in  = '0;
               phase_in  = PH_LEN;
               status_in = ST_HEADER;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         len_ff       <= '0;
         cmd_ff       <= '0;
         count_ff     <= '0;
         check_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            cmd_ff   <= cmd_in;
            count_ff <= count_in;
            check_ff <= check_in;
         end
      end
      if (take) begin
         status_ff  <= status_in;
         dbyte_ff   <= dbyte_in;
         dindex_ff  <= dindex_in;
         cmd_out_ff <= cmd_in;
         len_out_ff <= len_in;
         deliver_ff <= deliver_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.data_byte    = dbyte_ff;
   assign rsp_bus.data_index   = dindex_ff;
   assign rsp_bus.command_code = cmd_out_ff;
   assign rsp_bus.frame_length = len_out_ff;
   assign rsp_bus.deliver      = deliver_ff;

endmodule

`default_nettype wire

// ----- rtl/command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// command_frame_parser
// Byte-serial parser for start/length/command/data/check frames.
// ----------------------------------------------------------------------------
// One received byte per beat in, one result beat out per byte. Throughput is
// one byte per clock while the result side does not stall; a byte's result
// passes through the input register, then the frame state update into the
// result register. Stalls on the result side hold both register stages; once
// they are full, req ready follows rsp ready combinationally. Configuration
// writes are registered and are meant to land only while no byte is in flight.
`default_nettype none

module command_frame_parser import cfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   cfp_req_if.sink      req_bus,
   cfp_rsp_if.source    rsp_bus,
   cfp_csr_if.sink      csr_bus
);

   cfg_type  cfg;
   beat_type beat;
   logic     take;

   cfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   cfp_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .beat    (beat)
   );

   cfp_parser u_parse (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .cfg     (cfg),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- rtl/cfp_checker.sv -----
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker import cfp_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [BYTE_W-1:0]   rsp_data_byte,
   input wire logic [BYTE_W-1:0]   rsp_data_index,
   input wire logic                rsp_deliver
);

   // stalled beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_byte) && $stable(rsp_data_index) && $stable(rsp_deliver))
      else $error("result beat changed while stalled");

   a_deliver_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deliver |-> rsp_status == ST_GOOD)
      else $error("deliver without good frame");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DATA |-> rsp_data_byte == '0 && rsp_data_index == '0)
      else $error("data fields set outside data beat");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_IGNORED || rsp_status == ST_HEADER
         || rsp_status == ST_DATA || rsp_status == ST_GOOD || rsp_status == ST_BAD)
      else $error("status code out of range");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_data_byte  (rsp_bus.data_byte),
   .rsp_data_index (rsp_bus.data_index),
   .rsp_deliver    (rsp_bus.deliver)
);

`default_nettype wire
